[design/swa_pkg.sv]
// shared types and constants for the sensor scale and window average block
`default_nettype none

package swa_pkg;

  // sensor source codes carried on the input channel
  typedef enum logic [1:0] {
    SRC_CONFIG  = 2'd0,
    SRC_BATTERY = 2'd1,
    SRC_LIGHT   = 2'd2,
    SRC_NONE    = 2'd3
  } src_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BATTERY_SCALE = 2'd0,
    CFG_VOLTAGE_SCALE = 2'd1,
    CFG_CAL_VALID     = 2'd2,
    CFG_BATTERY_OFS   = 2'd3
  } cfg_idx_t;

  localparam int COUNT_W  = 12;
  localparam int SCALE_W  = 20;
  localparam int VALUE_W  = 16;
  localparam int OFS_W    = 16;
  localparam int CFG_W    = 20;
  localparam int FRAC_W   = 16;

  localparam logic [SCALE_W-1:0] BATTERY_SCALE_RST = 20'd103070;
  localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST = 20'd400000;
  localparam logic [VALUE_W-1:0] VALUE_MAX         = 16'hFFFF;

  // window bookkeeping handed from a window to the top level
  typedef struct packed {
    logic filled;
  } win_stat_t;

endpackage

`default_nettype wire

[design/swa_in_if.sv]
// input channel: sensor source and raw converter count
`default_nettype none

interface swa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  source;
  logic [11:0] raw_counts;

  modport src (output valid, output source, output raw_counts, input ready);
  modport snk (input valid, input source, input raw_counts, output ready);
endinterface

`default_nettype wire

[design/swa_out_if.sv]
// result channel: scaled value, window mean and fill flag
`default_nettype none

interface swa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] scaled_value;
  logic [15:0] window_mean;
  logic        mean_valid;

  modport src (output valid, output scaled_value, output window_mean, output mean_valid,
               input ready);
  modport snk (input valid, input scaled_value, input window_mean, input mean_valid,
               output ready);
endinterface

`default_nettype wire

[design/swa_cell.sv]
// one window entry: takes its neighbor's sample on every shift
`default_nettype none

module swa_cell (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        shift,
  input  wire logic [15:0] d,
  output logic      [15:0] q
);

  logic [15:0] entry_r;

  // entry register, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (shift) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;

endmodule

`default_nettype wire

[design/swa_window.sv]
// boxcar window: a row of cells, a running sum and a fill counter
`default_nettype none

module swa_window #(
  parameter int WINDOW_LENGTH = 10,
  parameter int SUM_W         = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [15:0]          din,
  output logic      [SUM_W-1:0]     sum,
  output swa_pkg::win_stat_t        stat
);

  localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LENGTH);

  logic [15:0]      tap [WINDOW_LENGTH];
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_r;

  // chain of cells, newest sample enters cell zero
  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      swa_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(push), .d(din), .q(tap[i]));
    end else begin : g_body
      swa_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(push), .d(tap[i-1]), .q(tap[i]));
    end
  end

  // running sum drops the oldest sample and adds the new one
  assign sum_nxt = sum_r - SUM_W'(tap[WINDOW_LENGTH-1]) + SUM_W'(din);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (push) begin
      sum_r <= sum_nxt;
      if (cnt_r != FULL_CNT) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign sum         = sum_r;
  assign stat.filled = (cnt_r == FULL_CNT);

endmodule

`default_nettype wire

[design/sensor_scale_and_window_average.sv]
// top level: per-source scaling, calibration, boxcar windows and mean
//
//  channel  dir   signals                                          transfer when
//  in_ch    in    source[2], raw_counts[12]                        valid & ready
//  out_ch   out   scaled_value[16], window_mean[16], mean_valid    valid & ready
//  cfg      in    cfg_we, cfg_index[2], cfg_wdata[20]              cfg_we high
//
// one item per cycle unless the output stalls; results pass stage registers a to d
// stages: scale multiply, calibrate and clamp, window push, mean by reciprocal multiply
// the rate is set by the running-sum register of each window, updated once per push
// reset is synchronous active low and clears the windows, sums and fill counters at once
// each stage holds when the one after it is full and stalled; bubbles close up
`default_nettype none

module sensor_scale_and_window_average #(
  parameter int WINDOW_LENGTH = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  swa_in_if.snk              in_ch,
  swa_out_if.src             out_ch,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [19:0]   cfg_wdata
);

  localparam int SUM_W = $clog2(WINDOW_LENGTH * 65535 + 1);
  localparam int K     = SUM_W + $clog2(WINDOW_LENGTH);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [K-1:0] RECIP = RECIP_FULL[K-1:0];

  // configuration registers
  logic [swa_pkg::SCALE_W-1:0] bat_scale_r;
  logic [swa_pkg::SCALE_W-1:0] volt_scale_r;
  logic                        cal_valid_r;
  logic [swa_pkg::OFS_W-1:0]   bat_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bat_scale_r  <= swa_pkg::BATTERY_SCALE_RST;
      volt_scale_r <= swa_pkg::VOLTAGE_SCALE_RST;
      cal_valid_r  <= 1'b0;
      bat_ofs_r    <= '0;
    end else if (cfg_we) begin
      unique case (swa_pkg::cfg_idx_t'(cfg_index))
        swa_pkg::CFG_BATTERY_SCALE: bat_scale_r  <= cfg_wdata;
        swa_pkg::CFG_VOLTAGE_SCALE: volt_scale_r <= cfg_wdata;
        swa_pkg::CFG_CAL_VALID:     cal_valid_r  <= cfg_wdata[0];
        swa_pkg::CFG_BATTERY_OFS:   bat_ofs_r    <= cfg_wdata[swa_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic va_r, vb_r, vc_r, vd_r;
  logic en_a, en_b, en_c, en_d;

  assign en_d = !vd_r || out_ch.ready;
  assign en_c = !vc_r || en_d;
  assign en_b = !vb_r || en_c;
  assign en_a = !va_r || en_b;
  assign in_ch.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_ch.valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      if (en_d) vd_r <= vc_r;
    end
  end

  // stage a: scale multiply, fraction dropped
  swa_pkg::src_t               src_in;
  logic [swa_pkg::SCALE_W-1:0] factor;
  logic [31:0]                 prod_full;
  swa_pkg::src_t               src_a_r;
  logic [swa_pkg::VALUE_W-1:0] prod_a_r;

  assign src_in    = swa_pkg::src_t'(in_ch.source);
  assign factor    = (src_in == swa_pkg::SRC_BATTERY) ? bat_scale_r : volt_scale_r;
  assign prod_full = 32'(in_ch.raw_counts) * 32'(factor);

  always_ff @(posedge clk) begin
    if (en_a && in_ch.valid) begin
      src_a_r  <= src_in;
      prod_a_r <= prod_full[swa_pkg::FRAC_W +: swa_pkg::VALUE_W];
    end
  end

  // stage b: calibration offset and clamp for battery samples; no-source values are zeroed
  logic signed [17:0]          cal_sum;
  logic [swa_pkg::VALUE_W-1:0] value_nxt;
  swa_pkg::src_t               src_b_r;
  logic [swa_pkg::VALUE_W-1:0] value_b_r;

  assign cal_sum = $signed({2'b00, prod_a_r}) + 18'(signed'(bat_ofs_r));

  always_comb begin
    value_nxt = prod_a_r;
    unique case (src_a_r)
      swa_pkg::SRC_BATTERY: begin
        if (cal_valid_r) begin
          if (cal_sum < 0) begin
            value_nxt = '0;
          end else if (cal_sum > 18'sd65535) begin
            value_nxt = swa_pkg::VALUE_MAX;
          end else begin
            value_nxt = cal_sum[swa_pkg::VALUE_W-1:0];
          end
        end
      end
      swa_pkg::SRC_NONE: value_nxt = '0;
      default: value_nxt = prod_a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_b && va_r) begin
      src_b_r   <= src_a_r;
      value_b_r <= value_nxt;
    end
  end

  // stage c: push into the source's window
  logic               push_bat, push_lgt;
  logic [SUM_W-1:0]   bat_sum, lgt_sum;
  swa_pkg::win_stat_t bat_stat, lgt_stat;
  swa_pkg::src_t      src_c_r;
  logic [swa_pkg::VALUE_W-1:0] value_c_r;

  assign push_bat = vb_r && en_c && (src_b_r == swa_pkg::SRC_BATTERY);
  assign push_lgt = vb_r && en_c && (src_b_r == swa_pkg::SRC_LIGHT);

  swa_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_bat_win (
    .clk(clk), .rst_n(rst_n), .push(push_bat), .din(value_b_r),
    .sum(bat_sum), .stat(bat_stat)
  );

  swa_window #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_lgt_win (
    .clk(clk), .rst_n(rst_n), .push(push_lgt), .din(value_b_r),
    .sum(lgt_sum), .stat(lgt_stat)
  );

  always_ff @(posedge clk) begin
    if (en_c && vb_r) begin
      src_c_r   <= src_b_r;
      value_c_r <= value_b_r;
    end
  end

  // stage d: mean as sum times reciprocal, into the output register
  logic [SUM_W-1:0]            sel_sum;
  logic                        sel_filled;
  logic                        has_win;
  logic [SUM_W+K-1:0]          mean_prod;
  logic [swa_pkg::VALUE_W-1:0] value_d_r;
  logic [swa_pkg::VALUE_W-1:0] mean_d_r;
  logic                        mvalid_d_r;

  always_comb begin
    sel_sum    = '0;
    sel_filled = 1'b0;
    has_win    = 1'b0;
    unique case (src_c_r)
      swa_pkg::SRC_BATTERY: begin
        sel_sum    = bat_sum;
        sel_filled = bat_stat.filled;
        has_win    = 1'b1;
      end
      swa_pkg::SRC_LIGHT: begin
        sel_sum    = lgt_sum;
        sel_filled = lgt_stat.filled;
        has_win    = 1'b1;
      end
      default: has_win = 1'b0;
    endcase
  end

  assign mean_prod = (SUM_W+K)'(sel_sum) * (SUM_W+K)'(RECIP);

  always_ff @(posedge clk) begin
    if (en_d && vc_r) begin
      value_d_r  <= value_c_r;
      mean_d_r   <= has_win ? mean_prod[K +: swa_pkg::VALUE_W] : '0;
      mvalid_d_r <= has_win && sel_filled;
    end
  end

  assign out_ch.valid        = vd_r;
  assign out_ch.scaled_value = value_d_r;
  assign out_ch.window_mean  = mean_d_r;
  assign out_ch.mean_valid   = mvalid_d_r;

endmodule

`default_nettype wire

[design/swa_checker.sv]
// port-level checks for the sensor scale and window average block
`default_nettype none

module swa_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] out_scaled_value,
  input wire logic [15:0] out_window_mean,
  input wire logic out_mean_valid
);

  logic [2:0] pending_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // items inside the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled_value)
      && $stable(out_window_mean) && $stable(out_mean_valid))
    else $error("result changed while stalled");

  // no result is shown without an accepted item behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without a pending item");

  // pipeline holds at most four items
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("more items in flight than stages");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sensor_scale_and_window_average swa_checker u_swa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_scaled_value(out_ch.scaled_value),
  .out_window_mean(out_ch.window_mean),
  .out_mean_valid(out_ch.mean_valid)
);

`default_nettype wire

[verif/tb_sensor_scale_and_window_average.sv]
// self-checking testbench for the sensor scale and window average block
module tb_sensor_scale_and_window_average;

  localparam int WIN_LEN      = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 120;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 96;

  // one result transfer as the block presents it
  typedef struct packed {
    logic [15:0] scaled_value;
    logic [15:0] window_mean;
    logic        mean_valid;
  } sample_result_t;

  // directed rows: a transfer checked by prediction, one with a typed result, or a register write
  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [1:0]     sel;    // source for transfers, register index for writes
    logic [19:0]    data;   // raw counts for transfers, write data for writes
    sample_result_t result;
  } row_t;

  localparam sample_result_t ZERO_RESULT = '0;

  localparam row_t DIRECTED [27] = '{
    // reset settings: unused code, zero counts, both extremes
    '{ROW_TYPED,   swa_pkg::SRC_NONE,          20'h00FFF, ZERO_RESULT},
    '{ROW_TYPED,   swa_pkg::SRC_CONFIG,        20'h00000, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_CONFIG,        20'h00FFF, ZERO_RESULT},
    '{ROW_TYPED,   swa_pkg::SRC_BATTERY,       20'h00000, ZERO_RESULT},
    '{ROW_TYPED,   swa_pkg::SRC_LIGHT,         20'h00000, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_BATTERY,       20'h00FFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_LIGHT,         20'h00FFF, ZERO_RESULT},
    '{ROW_TYPED,   swa_pkg::SRC_NONE,          20'h00000, ZERO_RESULT},
    // most negative offset, calibration on, upper write bits set
    '{ROW_WRITE,   swa_pkg::CFG_BATTERY_OFS,   20'hF8000, ZERO_RESULT},
    '{ROW_WRITE,   swa_pkg::CFG_CAL_VALID,     20'hFFFFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_BATTERY,       20'h00000, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_BATTERY,       20'h00064, ZERO_RESULT},
    // most positive offset with full scale saturates high
    '{ROW_WRITE,   swa_pkg::CFG_BATTERY_OFS,   20'h07FFF, ZERO_RESULT},
    '{ROW_WRITE,   swa_pkg::CFG_BATTERY_SCALE, 20'hFFFFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_BATTERY,       20'h00FFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_BATTERY,       20'h00000, ZERO_RESULT},
    // zero scales, calibration off
    '{ROW_WRITE,   swa_pkg::CFG_VOLTAGE_SCALE, 20'h00000, ZERO_RESULT},
    '{ROW_WRITE,   swa_pkg::CFG_BATTERY_SCALE, 20'h00000, ZERO_RESULT},
    '{ROW_WRITE,   swa_pkg::CFG_CAL_VALID,     20'hFFFFE, ZERO_RESULT},
    '{ROW_TYPED,   swa_pkg::SRC_CONFIG,        20'h00FFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_LIGHT,         20'h00FFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_BATTERY,       20'h00FFF, ZERO_RESULT},
    // full voltage scale
    '{ROW_WRITE,   swa_pkg::CFG_VOLTAGE_SCALE, 20'hFFFFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_CONFIG,        20'h00FFF, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_LIGHT,         20'h00800, ZERO_RESULT},
    '{ROW_PREDICT, swa_pkg::SRC_LIGHT,         20'h00FFF, ZERO_RESULT},
    '{ROW_TYPED,   swa_pkg::SRC_NONE,          20'h00FFF, ZERO_RESULT}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_wdata;

  swa_in_if  in_ch ();
  swa_out_if out_ch ();

  sensor_scale_and_window_average #(
    .WINDOW_LENGTH(WIN_LEN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the register file
  logic [19:0]        bat_scale;
  logic [19:0]        volt_scale;
  logic               cal_on;
  logic signed [15:0] bat_ofs;

  // mirror of the two windows: index 0 battery, 1 light
  logic [15:0] win_entry [2][WIN_LEN];
  int          win_slot [2];
  logic        win_full [2];
  logic [19:0] win_sum [2];

  sample_result_t expected_readings [$];
  int             mismatch_count;
  int             cycle_count;
  bit             tx_burst;
  bit             long_stall_pending;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // scale one sample, calibrate, clamp and push it into its window
  function automatic sample_result_t scale_and_average(swa_pkg::src_t src, logic [11:0] cnt);
    sample_result_t r;
    logic [19:0]    factor;
    logic [31:0]    product;
    int             level;
    int             w;
    r = '0;
    if (src == swa_pkg::SRC_NONE) return r;
    factor  = (src == swa_pkg::SRC_BATTERY) ? bat_scale : volt_scale;
    product = 32'(cnt) * 32'(factor);
    level   = int'(product[31:16]);
    if (src == swa_pkg::SRC_BATTERY && cal_on) level += int'(bat_ofs);
    if (level < 0) level = 0;
    else if (level > 65535) level = 65535;
    r.scaled_value = level[15:0];
    if (src == swa_pkg::SRC_CONFIG) return r;
    w = (src == swa_pkg::SRC_BATTERY) ? 0 : 1;
    win_sum[w] = win_sum[w] - 20'(win_entry[w][win_slot[w]]) + 20'(r.scaled_value);
    win_entry[w][win_slot[w]] = r.scaled_value;
    win_slot[w]++;
    if (win_slot[w] == WIN_LEN) begin
      win_slot[w] = 0;
      win_full[w] = 1'b1;
    end
    r.window_mean = 16'(win_sum[w] / WIN_LEN);
    r.mean_valid  = win_full[w];
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // offer one item, predict at its transfer, then idle a while unless in a burst phase
  task automatic send_item(swa_pkg::src_t src, logic [11:0] cnt, bit typed,
                           sample_result_t typed_result);
    sample_result_t predicted;
    int             gap;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.source     <= src;
    in_ch.raw_counts <= cnt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = scale_and_average(src, cnt);
    expected_readings.push_back(typed ? typed_result : predicted);
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid      <= 1'b0;
      in_ch.source     <= 2'($urandom);
      in_ch.raw_counts <= 12'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and let every expected result come out
  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(swa_pkg::cfg_idx_t idx, logic [19:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      swa_pkg::CFG_BATTERY_SCALE: bat_scale = data;
      swa_pkg::CFG_VOLTAGE_SCALE: volt_scale = data;
      swa_pkg::CFG_CAL_VALID:     cal_on = data[0];
      swa_pkg::CFG_BATTERY_OFS:   bat_ofs = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus: reset, directed table, then random phases under several settings
  initial begin : stimulus
    swa_pkg::src_t src;
    logic [11:0]   cnt;
    logic [19:0]   wdata;
    int            r;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.source       = '0;
    in_ch.raw_counts   = '0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    tx_burst           = 1'b0;
    long_stall_pending = 1'b0;
    mismatch_count     = 0;
    bat_scale          = swa_pkg::BATTERY_SCALE_RST;
    volt_scale         = swa_pkg::VOLTAGE_SCALE_RST;
    cal_on             = 1'b0;
    bat_ofs            = '0;
    for (int w = 0; w < 2; w++) begin
      win_slot[w] = 0;
      win_full[w] = 1'b0;
      win_sum[w]  = '0;
      for (int k = 0; k < WIN_LEN; k++) win_entry[w][k] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain_pipeline();
        write_reg(swa_pkg::cfg_idx_t'(DIRECTED[i].sel), DIRECTED[i].data);
      end else begin
        send_item(swa_pkg::src_t'(DIRECTED[i].sel), DIRECTED[i].data[11:0],
                  DIRECTED[i].kind == ROW_TYPED, DIRECTED[i].result);
      end
    end

    // random phases, each with its own register setting
    for (int p = 0; p < 5; p++) begin
      drain_pipeline();
      case (p)
        0: begin
          write_reg(swa_pkg::CFG_BATTERY_SCALE, swa_pkg::BATTERY_SCALE_RST);
          write_reg(swa_pkg::CFG_VOLTAGE_SCALE, swa_pkg::VOLTAGE_SCALE_RST);
          write_reg(swa_pkg::CFG_CAL_VALID, 20'd0);
          write_reg(swa_pkg::CFG_BATTERY_OFS, 20'd0);
        end
        1: begin
          write_reg(swa_pkg::CFG_BATTERY_SCALE, 20'($urandom));
          write_reg(swa_pkg::CFG_VOLTAGE_SCALE, 20'($urandom));
          write_reg(swa_pkg::CFG_CAL_VALID, 20'd1);
          write_reg(swa_pkg::CFG_BATTERY_OFS, 20'($urandom));
        end
        2: begin
          write_reg(swa_pkg::CFG_BATTERY_SCALE, 20'hFFFFF);
          write_reg(swa_pkg::CFG_VOLTAGE_SCALE, 20'hFFFFF);
          write_reg(swa_pkg::CFG_CAL_VALID, 20'hFFFFF);
          wdata = 20'($urandom);
          wdata[15:0] = 16'h7FFF;
          write_reg(swa_pkg::CFG_BATTERY_OFS, wdata);
        end
        3: begin
          write_reg(swa_pkg::CFG_BATTERY_SCALE, 20'($urandom_range(0, 131071)));
          write_reg(swa_pkg::CFG_VOLTAGE_SCALE, 20'($urandom_range(0, 131071)));
          write_reg(swa_pkg::CFG_CAL_VALID, 20'd1);
          wdata = 20'($urandom);
          wdata[15:0] = 16'h8000;
          write_reg(swa_pkg::CFG_BATTERY_OFS, wdata);
        end
        default: begin
          write_reg(swa_pkg::CFG_BATTERY_SCALE, 20'($urandom));
          write_reg(swa_pkg::CFG_VOLTAGE_SCALE, 20'($urandom));
          write_reg(swa_pkg::CFG_CAL_VALID, 20'($urandom));
          write_reg(swa_pkg::CFG_BATTERY_OFS, 20'($urandom));
        end
      endcase
      // back-to-back offers in one phase; receiver hold-off in two others
      tx_burst = (p == 2);
      if (p == 1 || p == 3) long_stall_pending = 1'b1;
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 40) src = swa_pkg::SRC_BATTERY;
        else if (r < 80) src = swa_pkg::SRC_LIGHT;
        else if (r < 92) src = swa_pkg::SRC_CONFIG;
        else src = swa_pkg::SRC_NONE;
        r = $urandom_range(0, 15);
        if (r == 0) cnt = 12'h000;
        else if (r == 1) cnt = 12'hFFF;
        else cnt = 12'($urandom);
        send_item(src, cnt, 1'b0, ZERO_RESULT);
      end
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side ready: random runs and gaps, plus a long hold-off on request
  initial begin : result_sink
    int left;
    out_ch.ready = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_stall_pending) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        long_stall_pending = 1'b0;
        left = 0;
      end else if (left > 0) begin
        left--;
      end else if (out_ch.ready) begin
        out_ch.ready <= 1'b0;
        left = pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
        left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    sample_result_t exp_r;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_readings.size() == 0) begin
        $error("result with nothing expected: scaled_value %0d window_mean %0d mean_valid %0d",
               out_ch.scaled_value, out_ch.window_mean, out_ch.mean_valid);
        mismatch_count++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_ch.scaled_value !== exp_r.scaled_value) begin
          $error("scaled_value: expected %0d, got %0d", exp_r.scaled_value, out_ch.scaled_value);
          mismatch_count++;
        end
        if (out_ch.window_mean !== exp_r.window_mean) begin
          $error("window_mean: expected %0d, got %0d", exp_r.window_mean, out_ch.window_mean);
          mismatch_count++;
        end
        if (out_ch.mean_valid !== exp_r.mean_valid) begin
          $error("mean_valid: expected %0d, got %0d", exp_r.mean_valid, out_ch.mean_valid);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

[files.f]
design/swa_pkg.sv
design/swa_in_if.sv
design/swa_out_if.sv
design/swa_cell.sv
design/swa_window.sv
design/sensor_scale_and_window_average.sv
design/swa_checker.sv
verif/tb_sensor_scale_and_window_average.sv
